[design/bpc_pkg.sv]
// Shared types and constants for the button press classifier.
package bpc_pkg;

  localparam int unsigned FIELD_W         = 5;
  localparam int unsigned CFG_W           = 16;
  localparam int unsigned CFG_IDX_W       = 2;
  localparam int unsigned NUM_BUTTONS_DEF = 5;
  localparam int unsigned COUNT_WIDTH_DEF = 16;

  localparam int unsigned DOWN_BTN = 0;
  localparam int unsigned UP_BTN   = 1;
  localparam int unsigned BAND_BTN = 4;

  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MAX = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LONG      = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LOCK      = 2'd3;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST  = 16'd5;
  localparam logic [CFG_W-1:0] SHORT_MAX_RST = 16'd50;
  localparam logic [CFG_W-1:0] LONG_RST      = 16'd100;
  localparam logic [CFG_W-1:0] LOCK_RST      = 16'd100;

  typedef struct packed {
    logic [CFG_W-1:0] debounce_ticks;
    logic [CFG_W-1:0] short_max_ticks;
    logic [CFG_W-1:0] long_ticks;
    logic [CFG_W-1:0] lock_ticks;
  } cfg_t;

  typedef struct packed {
    logic short_hit;
    logic long_hit;
    logic pressed;
  } lane_res_t;

endpackage

[design/bpc_lane.sv]
// Per-button lane: debounce, hold timing and short/long press detection.
module bpc_lane #(
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               accept_i,
  input  logic               raw_i,
  input  bpc_pkg::cfg_t      cfg_i,
  output bpc_pkg::lane_res_t res_o
);
  import bpc_pkg::*;

  localparam int unsigned CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic                   stable_q, stable_d;
  logic                   prev_q, prev_d;
  logic                   handled_q, handled_d;
  logic [COUNT_WIDTH-1:0] mis_q, mis_d;
  logic [COUNT_WIDTH-1:0] hold_q, hold_d;

  logic [COUNT_WIDTH-1:0] mis_inc;
  logic [COUNT_WIDTH-1:0] hold_base;
  logic                   handled_base;
  logic                   change;
  logic                   long_hit;
  logic                   short_hit;
  logic [CMP_W-1:0]       hold_x;
  logic [CMP_W-1:0]       deb_x;

  assign deb_x   = CMP_W'(cfg_i.debounce_ticks);
  assign mis_inc = (mis_q == CNT_MAX) ? mis_q : mis_q + 1'b1;
  assign change  = (raw_i != stable_q) && (CMP_W'(mis_inc) >= deb_x);

  always_comb begin
    stable_d     = stable_q;
    prev_d       = prev_q;
    hold_base    = hold_q;
    handled_base = handled_q;
    if (raw_i != stable_q) begin
      mis_d = mis_inc;
      if (change) begin
        prev_d   = stable_q;
        stable_d = raw_i;
        mis_d    = '0;
        if (!raw_i) begin
          hold_base    = '0;
          handled_base = 1'b0;
        end
      end
    end else begin
      mis_d = '0;
    end

    hold_d = hold_base;
    if (!stable_d && hold_base != CNT_MAX) begin
      hold_d = hold_base + 1'b1;
    end
    hold_x = CMP_W'(hold_d);

    long_hit  = !stable_d && !handled_base && (hold_x >= CMP_W'(cfg_i.long_ticks));
    short_hit = !prev_d && stable_d && !handled_base && (hold_x >= deb_x)
                && (hold_x < CMP_W'(cfg_i.short_max_ticks));
    handled_d = handled_base | long_hit | short_hit;
  end

  assign res_o.short_hit = short_hit;
  assign res_o.long_hit  = long_hit;
  assign res_o.pressed   = !stable_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stable_q  <= 1'b1;
      prev_q    <= 1'b1;
      handled_q <= 1'b0;
      mis_q     <= '0;
      hold_q    <= '0;
    end else if (accept_i) begin
      stable_q  <= stable_d;
      prev_q    <= prev_d;
      handled_q <= handled_d;
      mis_q     <= mis_d;
      hold_q    <= hold_d;
    end
  end

  a_short_not_long: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(res_o.short_hit && res_o.long_hit))
    else $error("short and long press in the same tick");

  a_short_marks_handled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && res_o.short_hit |=> handled_q)
    else $error("short press left the press unhandled");

  a_long_marks_handled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && res_o.long_hit |=> handled_q && !stable_q)
    else $error("long press state not recorded");

endmodule

[design/bpc_merge.sv]
// Merge stage: lock combo, event masking and the output register.
module bpc_merge #(
  parameter int unsigned NUM_BUTTONS = 5,
  parameter int unsigned COUNT_WIDTH = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   accept_i,
  input  bpc_pkg::lane_res_t [NUM_BUTTONS-1:0]   lanes_i,
  input  logic [bpc_pkg::CFG_W-1:0]              lock_ticks_i,
  input  logic                                   out_stall_i,
  output logic                                   out_valid_o,
  output logic [bpc_pkg::FIELD_W-1:0]            short_events_o,
  output logic [bpc_pkg::FIELD_W-1:0]            long_events_o,
  output logic                                   lock_toggled_o,
  output logic                                   lock_state_o,
  output logic [bpc_pkg::FIELD_W-1:0]            pressed_levels_o
);
  import bpc_pkg::*;

  localparam int unsigned CMP_W = (COUNT_WIDTH > CFG_W) ? COUNT_WIDTH : CFG_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

  logic                   lock_q, lock_d;
  logic                   active_q, active_d;
  logic                   done_q, done_d;
  logic [COUNT_WIDTH-1:0] combo_q, combo_d;
  logic                   toggled;

  logic                   valid_q, valid_d;
  logic [FIELD_W-1:0]     short_q, short_d;
  logic [FIELD_W-1:0]     long_q, long_d;
  logic [FIELD_W-1:0]     pressed_q, pressed_d;
  logic                   toggled_q;

  always_comb begin
    lock_d   = lock_q;
    active_d = active_q;
    done_d   = done_q;
    combo_d  = combo_q;
    toggled  = 1'b0;
    if (lanes_i[DOWN_BTN].pressed && lanes_i[UP_BTN].pressed) begin
      if (!active_q) begin
        active_d = 1'b1;
        combo_d  = '0;
        done_d   = 1'b0;
      end else if (!done_q) begin
        combo_d = (combo_q == CNT_MAX) ? combo_q : combo_q + 1'b1;
        if (CMP_W'(combo_d) >= CMP_W'(lock_ticks_i)) begin
          lock_d  = !lock_q;
          done_d  = 1'b1;
          toggled = 1'b1;
        end
      end
    end else begin
      active_d = 1'b0;
    end
  end

  for (genvar i = 0; i < FIELD_W; i++) begin : g_bits
    if (i < NUM_BUTTONS) begin : g_lane
      assign short_d[i]   = lanes_i[i].short_hit && (!lock_q || (i == BAND_BTN));
      assign long_d[i]    = lanes_i[i].long_hit && !lock_q;
      assign pressed_d[i] = lanes_i[i].pressed;
    end else begin : g_none
      assign short_d[i]   = 1'b0;
      assign long_d[i]    = 1'b0;
      assign pressed_d[i] = 1'b0;
    end
  end

  assign valid_d = accept_i || (valid_q && out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lock_q    <= 1'b0;
      active_q  <= 1'b0;
      done_q    <= 1'b0;
      combo_q   <= '0;
      valid_q   <= 1'b0;
      short_q   <= '0;
      long_q    <= '0;
      pressed_q <= '0;
      toggled_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (accept_i) begin
        lock_q    <= lock_d;
        active_q  <= active_d;
        done_q    <= done_d;
        combo_q   <= combo_d;
        short_q   <= short_d;
        long_q    <= long_d;
        pressed_q <= pressed_d;
        toggled_q <= toggled;
      end
    end
  end

  assign out_valid_o      = valid_q;
  assign short_events_o   = short_q;
  assign long_events_o    = long_q;
  assign lock_toggled_o   = toggled_q;
  assign lock_state_o     = lock_q;
  assign pressed_levels_o = pressed_q;

  a_lock_follows_toggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |=> lock_q == ($past(lock_q) ^ toggled_q))
    else $error("lock flag changed without a toggle");

  a_combo_starts_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(active_q) |-> (combo_q == '0) && !done_q)
    else $error("combo started with stale count");

  a_beat_drains: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !out_stall_i && !accept_i |=> !valid_q)
    else $error("taken beat still shown as valid");

  a_toggle_needs_combo: assert property (@(posedge clk_i) disable iff (!rst_ni)
    toggled |-> active_q && lanes_i[DOWN_BTN].pressed && lanes_i[UP_BTN].pressed)
    else $error("lock toggled outside a combo");

endmodule

[design/button_press_classifier.sv]
// Button press classifier top level: config registers, button lanes and merge stage.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / raw_levels_i): one beat per scan
//   tick, bit i the raw active-low level of button i.
//   Output channel (out_valid_o / out_stall_i / result fields): one beat per
//   input beat, in order: short and long press events, lock toggle, lock
//   state and debounced pressed levels.
//   Config channel (cfg_valid_i / cfg_ready_o / cfg_index_i / cfg_data_i):
//   always ready; index 0 debounce, 1 short max, 2 long, 3 lock ticks.
//   Write only while no beat is in flight.
// Timing:
//   Output valid rises in the cycle after input accept. Throughput is one
//   beat per cycle unless the output stalls: all button lanes and the
//   combo check update in the accept cycle, and a single output register
//   holds the result. When the receiver stalls with a result waiting,
//   in_stall_o rises in the same cycle; the held beat stays put until taken.
// Reset:
//   All buttons read released, counters and lock clear, registers return to
//   5 / 50 / 100 / 100, no output beat pending.
module button_press_classifier #(
  parameter int unsigned NUM_BUTTONS = bpc_pkg::NUM_BUTTONS_DEF,
  parameter int unsigned COUNT_WIDTH = bpc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [bpc_pkg::FIELD_W-1:0]     raw_levels_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [bpc_pkg::FIELD_W-1:0]     short_events_o,
  output logic [bpc_pkg::FIELD_W-1:0]     long_events_o,
  output logic                            lock_toggled_o,
  output logic                            lock_state_o,
  output logic [bpc_pkg::FIELD_W-1:0]     pressed_levels_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [bpc_pkg::CFG_W-1:0]       cfg_data_i
);
  import bpc_pkg::*;

  cfg_t                         cfg_q;
  logic                         accept;
  logic [NUM_BUTTONS-1:0]       raw;
  lane_res_t [NUM_BUTTONS-1:0]  lanes;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = out_valid_o && out_stall_i;
  assign accept      = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ticks  <= DEBOUNCE_RST;
      cfg_q.short_max_ticks <= SHORT_MAX_RST;
      cfg_q.long_ticks      <= LONG_RST;
      cfg_q.lock_ticks      <= LOCK_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_DEBOUNCE:  cfg_q.debounce_ticks  <= cfg_data_i;
        CFG_SHORT_MAX: cfg_q.short_max_ticks <= cfg_data_i;
        CFG_LONG:      cfg_q.long_ticks      <= cfg_data_i;
        CFG_LOCK:      cfg_q.lock_ticks      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_lane
    if (i < FIELD_W) begin : g_in
      assign raw[i] = raw_levels_i[i];
    end else begin : g_zero
      assign raw[i] = 1'b0;
    end

    bpc_lane #(
      .COUNT_WIDTH(COUNT_WIDTH)
    ) u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .accept_i(accept),
      .raw_i   (raw[i]),
      .cfg_i   (cfg_q),
      .res_o   (lanes[i])
    );
  end

  bpc_merge #(
    .NUM_BUTTONS(NUM_BUTTONS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_merge (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .lanes_i         (lanes),
    .lock_ticks_i    (cfg_q.lock_ticks),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .short_events_o  (short_events_o),
    .long_events_o   (long_events_o),
    .lock_toggled_o  (lock_toggled_o),
    .lock_state_o    (lock_state_o),
    .pressed_levels_o(pressed_levels_o)
  );

endmodule

[test/button_press_classifier_test.sv]
// Self-checking testbench for the button press classifier: table drill, then random gestures.
`timescale 1ns / 1ps

module button_press_classifier_test;
  import bpc_pkg::*;

  localparam int BUTTONS = NUM_BUTTONS_DEF;

  typedef struct packed {
    logic [FIELD_W-1:0] shorts;
    logic [FIELD_W-1:0] longs;
    logic               toggled;
    logic               locked;
    logic [FIELD_W-1:0] pressed;
  } tick_outcome_t;

  typedef struct packed {
    logic [FIELD_W-1:0] levels;
    logic               typed;
    tick_outcome_t      want;
  } drill_row_t;

  localparam tick_outcome_t NO_EVENTS = '0;
  localparam tick_outcome_t ALL_HELD  = '{5'h00, 5'h00, 1'b0, 1'b0, 5'h1f};

  // Drill runs with debounce 1, short max 4, long 6, lock 3.
  localparam drill_row_t DRILL [25] = '{
    '{5'h1f, 1'b1, NO_EVENTS},
    '{5'h00, 1'b1, ALL_HELD},
    '{5'h00, 1'b0, NO_EVENTS},
    '{5'h00, 1'b0, NO_EVENTS},
    '{5'h00, 1'b0, NO_EVENTS},  // combo toggles lock on
    '{5'h00, 1'b0, NO_EVENTS},
    '{5'h00, 1'b0, NO_EVENTS},  // long masked while locked
    '{5'h1f, 1'b0, NO_EVENTS},
    '{5'h0f, 1'b0, NO_EVENTS},
    '{5'h0f, 1'b0, NO_EVENTS},
    '{5'h1f, 1'b0, NO_EVENTS},  // band short passes the lock
    '{5'h1e, 1'b0, NO_EVENTS},
    '{5'h1f, 1'b0, NO_EVENTS},  // step short masked
    '{5'h1c, 1'b0, NO_EVENTS},
    '{5'h1c, 1'b0, NO_EVENTS},
    '{5'h1c, 1'b0, NO_EVENTS},
    '{5'h1c, 1'b0, NO_EVENTS},  // lock off again
    '{5'h1c, 1'b0, NO_EVENTS},
    '{5'h1c, 1'b0, NO_EVENTS},  // unmasked long on both steps
    '{5'h1f, 1'b0, NO_EVENTS},
    '{5'h17, 1'b0, NO_EVENTS},
    '{5'h1f, 1'b0, NO_EVENTS},
    '{5'h15, 1'b0, NO_EVENTS},
    '{5'h0a, 1'b0, NO_EVENTS},
    '{5'h1f, 1'b0, NO_EVENTS}
  };

  logic                 clk_i;
  logic                 rst_ni       = 1'b0;
  logic                 in_valid_i   = 1'b0;
  logic                 in_stall_o;
  logic [FIELD_W-1:0]   raw_levels_i = '1;
  logic                 out_valid_o;
  logic                 out_stall_i  = 1'b0;
  logic [FIELD_W-1:0]   short_events_o;
  logic [FIELD_W-1:0]   long_events_o;
  logic                 lock_toggled_o;
  logic                 lock_state_o;
  logic [FIELD_W-1:0]   pressed_levels_o;
  logic                 cfg_valid_i  = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i  = CFG_DEBOUNCE;
  logic [CFG_W-1:0]     cfg_data_i   = '0;

  button_press_classifier dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .raw_levels_i     (raw_levels_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .short_events_o   (short_events_o),
    .long_events_o    (long_events_o),
    .lock_toggled_o   (lock_toggled_o),
    .lock_state_o     (lock_state_o),
    .pressed_levels_o (pressed_levels_o),
    .cfg_valid_i      (cfg_valid_i),
    .cfg_ready_o      (cfg_ready_o),
    .cfg_index_i      (cfg_index_i),
    .cfg_data_i       (cfg_data_i)
  );

  cfg_t          cfg_shadow;
  logic          stable_lvl [BUTTONS];
  logic          prior_lvl  [BUTTONS];
  logic          handled    [BUTTONS];
  logic [15:0]   glitch_cnt [BUTTONS];
  logic [15:0]   hold_cnt   [BUTTONS];
  logic [15:0]   combo_cnt;
  logic          combo_on;
  logic          combo_fired;
  logic          lock_on;

  tick_outcome_t tick_outcomes_q [$];
  tick_outcome_t seen_beat;
  tick_outcome_t due_beat;

  int send_idle_pct = 0;
  int stall_pct     = 0;
  int ticks_sent    = 0;
  int beats_seen    = 0;
  int mismatches    = 0;
  int shorts_seen   = 0;
  int longs_seen    = 0;
  int toggles_seen  = 0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("button_press_classifier_test: done, errors");
    $finish;
  end

  function automatic logic [15:0] bump(input logic [15:0] v);
    return (v == 16'hffff) ? v : v + 16'd1;
  endfunction

  task automatic reset_model();
    cfg_shadow = '{DEBOUNCE_RST, SHORT_MAX_RST, LONG_RST, LOCK_RST};
    for (int b = 0; b < BUTTONS; b++) begin
      stable_lvl[b] = 1'b1;
      prior_lvl[b]  = 1'b1;
      handled[b]    = 1'b0;
      glitch_cnt[b] = '0;
      hold_cnt[b]   = '0;
    end
    combo_cnt   = '0;
    combo_on    = 1'b0;
    combo_fired = 1'b0;
    lock_on     = 1'b0;
  endtask

  function automatic tick_outcome_t classify_tick(input logic [FIELD_W-1:0] lv);
    tick_outcome_t r;
    logic          was_locked;
    logic          fire;
    r = '0;
    was_locked = lock_on;
    for (int b = 0; b < BUTTONS; b++) begin
      if (lv[b] != stable_lvl[b]) begin
        glitch_cnt[b] = bump(glitch_cnt[b]);
        if (glitch_cnt[b] >= cfg_shadow.debounce_ticks) begin
          prior_lvl[b]  = stable_lvl[b];
          stable_lvl[b] = lv[b];
          glitch_cnt[b] = '0;
          if (!lv[b]) begin
            hold_cnt[b] = '0;
            handled[b]  = 1'b0;
          end
        end
      end else begin
        glitch_cnt[b] = '0;
      end
      if (!stable_lvl[b]) hold_cnt[b] = bump(hold_cnt[b]);
      if (!stable_lvl[b] && !handled[b] && hold_cnt[b] >= cfg_shadow.long_ticks) begin
        if (!was_locked) r.longs[b] = 1'b1;
        handled[b] = 1'b1;
      end
      fire = !prior_lvl[b] && stable_lvl[b] && !handled[b]
             && hold_cnt[b] >= cfg_shadow.debounce_ticks
             && hold_cnt[b] < cfg_shadow.short_max_ticks;
      if (fire) begin
        if (!was_locked || b == BAND_BTN) r.shorts[b] = 1'b1;
        handled[b] = 1'b1;
      end
      r.pressed[b] = !stable_lvl[b];
    end
    if (!stable_lvl[DOWN_BTN] && !stable_lvl[UP_BTN]) begin
      if (!combo_on) begin
        combo_on    = 1'b1;
        combo_cnt   = '0;
        combo_fired = 1'b0;
      end else if (!combo_fired) begin
        combo_cnt = bump(combo_cnt);
        if (combo_cnt >= cfg_shadow.lock_ticks) begin
          lock_on     = !lock_on;
          combo_fired = 1'b1;
          r.toggled   = 1'b1;
        end
      end
    end else begin
      combo_on = 1'b0;
    end
    r.locked = lock_on;
    return r;
  endfunction

  // Called just after a falling edge; returns just after a falling edge.
  task automatic push_tick(input logic [FIELD_W-1:0] lv, input logic typed = 1'b0,
                           input tick_outcome_t want = '0);
    tick_outcome_t predicted;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i   <= 1'b1;
    raw_levels_i <= lv;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predicted = classify_tick(lv);
    tick_outcomes_q.push_back(typed ? want : predicted);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (tick_outcomes_q.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_one(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_DEBOUNCE:  cfg_shadow.debounce_ticks  = data;
      CFG_SHORT_MAX: cfg_shadow.short_max_ticks = data;
      CFG_LONG:      cfg_shadow.long_ticks      = data;
      default:       cfg_shadow.lock_ticks      = data;
    endcase
    @(negedge clk_i);
  endtask

  task automatic program_config(input logic [CFG_W-1:0] deb, input logic [CFG_W-1:0] smax,
                                input logic [CFG_W-1:0] lng, input logic [CFG_W-1:0] lck);
    write_one(CFG_DEBOUNCE, deb);
    write_one(CFG_SHORT_MAX, smax);
    write_one(CFG_LONG, lng);
    write_one(CFG_LOCK, lck);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic shuffle_config();
    program_config(CFG_W'($urandom_range(1, 6)), CFG_W'($urandom_range(1, 30)),
                   CFG_W'($urandom_range(1, 40)), CFG_W'($urandom_range(1, 30)));
  endtask

  task automatic play_gesture();
    logic [FIELD_W-1:0] held;
    logic [FIELD_W-1:0] lv;
    int                 deb;
    int                 dur;
    int                 rest;
    deb  = int'(cfg_shadow.debounce_ticks);
    held = ($urandom_range(3) == 0) ? 5'b00011 : FIELD_W'($urandom_range(1, 31));
    case ($urandom_range(4))
      0:       dur = $urandom_range(1, deb);
      1:       dur = deb + $urandom_range(0, int'(cfg_shadow.short_max_ticks) + 1);
      2:       dur = deb + int'(cfg_shadow.long_ticks) + $urandom_range(0, 4) - 2;
      3:       dur = deb + int'(cfg_shadow.lock_ticks) + $urandom_range(0, 3);
      default: dur = $urandom_range(1, 2 * deb + 8);
    endcase
    if (dur < 1) dur = 1;
    for (int t = 0; t < dur; t++) begin
      lv = ~held;
      if (t < deb && $urandom_range(3) == 0) lv ^= FIELD_W'($urandom);
      push_tick(lv);
    end
    rest = $urandom_range(0, deb + 3);
    for (int t = 0; t < rest; t++) begin
      lv = '1;
      if (t < deb && $urandom_range(3) == 0) lv ^= FIELD_W'($urandom);
      push_tick(lv);
    end
  endtask

  task automatic run_random(input int count);
    int stop_at;
    stop_at = ticks_sent + count;
    while (ticks_sent < stop_at) begin
      if ($urandom_range(199) == 0) settle();
      if ($urandom_range(9) < 7) begin
        play_gesture();
      end else begin
        repeat ($urandom_range(1, 6)) push_tick(FIELD_W'($urandom));
      end
    end
  endtask

  task automatic note_mismatch(input string what, input logic [FIELD_W-1:0] want,
                               input logic [FIELD_W-1:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch at beat %0d: %s expected %0h got %0h", beats_seen, what, want, got);
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen_beat = '{short_events_o, long_events_o, lock_toggled_o, lock_state_o,
                    pressed_levels_o};
      shorts_seen  += $countones(seen_beat.shorts);
      longs_seen   += $countones(seen_beat.longs);
      toggles_seen += int'(seen_beat.toggled);
      if (tick_outcomes_q.size() == 0) begin
        note_mismatch("beat with nothing pending", '0, seen_beat.pressed);
      end else begin
        due_beat = tick_outcomes_q.pop_front();
        if (seen_beat.shorts !== due_beat.shorts)
          note_mismatch("short_events", due_beat.shorts, seen_beat.shorts);
        if (seen_beat.longs !== due_beat.longs)
          note_mismatch("long_events", due_beat.longs, seen_beat.longs);
        if (seen_beat.toggled !== due_beat.toggled)
          note_mismatch("lock_toggled", FIELD_W'(due_beat.toggled),
                        FIELD_W'(seen_beat.toggled));
        if (seen_beat.locked !== due_beat.locked)
          note_mismatch("lock_state", FIELD_W'(due_beat.locked),
                        FIELD_W'(seen_beat.locked));
        if (seen_beat.pressed !== due_beat.pressed)
          note_mismatch("pressed_levels", due_beat.pressed, seen_beat.pressed);
      end
      beats_seen++;
    end
  end

  initial begin
    reset_model();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    program_config(16'd1, 16'd4, 16'd6, 16'd3);
    foreach (DRILL[k]) push_tick(DRILL[k].levels, DRILL[k].typed, DRILL[k].want);
    settle();

    send_idle_pct = 13;
    stall_pct     = 69;
    program_config(DEBOUNCE_RST, SHORT_MAX_RST, LONG_RST, LOCK_RST);
    run_random(520);
    settle();

    send_idle_pct = 69;
    stall_pct     = 13;
    shuffle_config();
    run_random(260);
    settle();
    shuffle_config();
    run_random(260);
    settle();

    send_idle_pct = 0;
    stall_pct     = 0;
    program_config(16'd1, 16'd1, 16'd1, 16'd1);
    run_random(250);
    settle();
    // Step buttons held with debounce 2 and short max, long and lock at full scale.
    program_config(16'd2, 16'hffff, 16'hffff, 16'hffff);
    repeat (30) push_tick(5'b11100);
    repeat (4) push_tick(5'h1f);
    settle();
    shuffle_config();
    run_random(260);
    settle();
    repeat (5) @(posedge clk_i);

    $display("covered %0d ticks, %0d beats checked, %0d mismatches", ticks_sent, beats_seen,
             mismatches);
    $display("events seen: %0d short, %0d long, %0d lock toggles", shorts_seen, longs_seen,
             toggles_seen);
    if (mismatches == 0) begin
      $display("button_press_classifier_test: done, clean");
    end else begin
      $display("button_press_classifier_test: done, errors");
    end
    $finish;
  end

endmodule
